>>> rtl/core/edfs_pkg.sv
// edfs_pkg: types, codes and constants shared by the deadline scheduler
// depends on nothing; used by edfs_cell and edf_job_scheduler
package edfs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned DL_W        = 24;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned EVENT_W     = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic signed [DL_W-1:0] DL_MIN = {1'b1, {(DL_W-1){1'b0}}};

  // command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // job types
  localparam logic [KIND_W-1:0] KIND_T0      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_T1      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_T2      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

  // event codes
  localparam logic [EVENT_W-1:0] EV_RECEIVE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_FINISH  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DROP    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORK_T0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_T0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_T1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_T1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_T2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_T2 = 3'd5;

  // register reset values
  localparam logic [TIME_W-1:0] RST_WORK_T0  = 16'd500;
  localparam logic [TIME_W-1:0] RST_LIMIT_T0 = 16'd2000;
  localparam logic [TIME_W-1:0] RST_WORK_T1  = 16'd1000;
  localparam logic [TIME_W-1:0] RST_LIMIT_T1 = 16'd3000;
  localparam logic [TIME_W-1:0] RST_WORK_T2  = 16'd200;
  localparam logic [TIME_W-1:0] RST_LIMIT_T2 = 16'd300;

  typedef struct packed {
    logic                   valid;
    logic [KIND_W-1:0]      kind;
    logic [TIME_W-1:0]      work;
    logic signed [DL_W-1:0] deadline;
    logic                   started;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic arrive;
    logic tick;
    logic finish;
    logic mark_start;
  } ctl_t;

endpackage

>>> rtl/core/edfs_cell.sv
// edfs_cell: one slot of the sorted job queue
// depends on edfs_pkg; chained by edf_job_scheduler
module edfs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  edfs_pkg::ctl_t  ctl_i,
  input  logic            head_i,
  input  edfs_pkg::entry_t new_i,
  input  edfs_pkg::entry_t left_i,
  input  logic            left_cond_i,
  input  edfs_pkg::entry_t right_tick_i,
  output edfs_pkg::entry_t entry_o,
  output edfs_pkg::entry_t tick_o,
  output logic            cond_o
);

  edfs_pkg::entry_t ent_q, ent_d;

  // slot is empty or holds a deadline not below the new one
  assign cond_o = !ent_q.valid || (ent_q.deadline >= new_i.deadline);

  // own entry as it looks after one tick
  always_comb begin
    tick_o = ent_q;
    if (ent_q.valid && ent_q.deadline != edfs_pkg::DL_MIN) begin
      tick_o.deadline = ent_q.deadline - edfs_pkg::DL_W'(1);
    end
    if (head_i && ent_q.work != '0) begin
      tick_o.work = ent_q.work - edfs_pkg::TIME_W'(1);
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.arrive) begin
      if (left_cond_i) begin
        ent_d = left_i;
      end else if (cond_o) begin
        ent_d = new_i;
      end
    end else if (ctl_i.tick) begin
      ent_d = ctl_i.finish ? right_tick_i : tick_o;
    end
    if (ctl_i.mark_start && head_i) begin
      ent_d.started = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign entry_o = ent_q;

endmodule

>>> rtl/core/edf_job_scheduler.sv
// edf_job_scheduler: preemptive earliest-deadline-first job queue, top level
// depends on edfs_pkg and edfs_cell
//
// usage
//   command channel: a transaction is taken at a rising edge with start high
//   and busy low; command_i 0 is a job arrival of type job_type_i, 1 is one
//   time tick
//   result channel: each result is shown for exactly one cycle with
//   res_valid_o high; last_o marks the final result of a command
//   config port: cfg_idx_i selects a work or limit register, written with cfg_wdata_i
//   on cfg_we_i high; the user must write only while idle, not enforced by the block
// timing
//   the queue is a row of cells; every cell updates in the edge that takes
//   the command, the next cycle inspects the head cell and registers the
//   first result; a second result (finish then receive) is registered from
//   the ST_SECOND state; busy stays high until the last result of a command
//   is registered, so no new command is taken before then
// reset
//   queue empties, serial counters clear, registers take their defaults
//   results cannot be held off by the receiver; none are buffered
module edf_job_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command_i,
  input  logic [edfs_pkg::KIND_W-1:0]    job_type_i,
  output logic                           res_valid_o,
  output logic [edfs_pkg::EVENT_W-1:0]   event_res_o,
  output logic [edfs_pkg::KIND_W-1:0]    job_type_res_o,
  output logic [edfs_pkg::TIME_W-1:0]    serial_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [edfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [edfs_pkg::TIME_W-1:0]    cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SECOND
  } state_e;

  state_e state_q;

  // configuration registers
  logic [edfs_pkg::TIME_W-1:0] work_t0_q, limit_t0_q, work_t1_q, limit_t1_q;
  logic [edfs_pkg::TIME_W-1:0] work_t2_q, limit_t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_t0_q  <= edfs_pkg::RST_WORK_T0;
      limit_t0_q <= edfs_pkg::RST_LIMIT_T0;
      work_t1_q  <= edfs_pkg::RST_WORK_T1;
      limit_t1_q <= edfs_pkg::RST_LIMIT_T1;
      work_t2_q  <= edfs_pkg::RST_WORK_T2;
      limit_t2_q <= edfs_pkg::RST_LIMIT_T2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        edfs_pkg::REG_WORK_T0:  work_t0_q  <= cfg_wdata_i;
        edfs_pkg::REG_LIMIT_T0: limit_t0_q <= cfg_wdata_i;
        edfs_pkg::REG_WORK_T1:  work_t1_q  <= cfg_wdata_i;
        edfs_pkg::REG_LIMIT_T1: limit_t1_q <= cfg_wdata_i;
        edfs_pkg::REG_WORK_T2:  work_t2_q  <= cfg_wdata_i;
        edfs_pkg::REG_LIMIT_T2: limit_t2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-type parameters of an arriving job
  logic [edfs_pkg::TIME_W-1:0] new_work, new_limit;
  logic                        type_ok;

  always_comb begin
    new_work  = work_t0_q;
    new_limit = limit_t0_q;
    type_ok   = 1'b1;
    case (job_type_i)
      edfs_pkg::KIND_T0: begin
        new_work  = work_t0_q;
        new_limit = limit_t0_q;
      end
      edfs_pkg::KIND_T1: begin
        new_work  = work_t1_q;
        new_limit = limit_t1_q;
      end
      edfs_pkg::KIND_T2: begin
        new_work  = work_t2_q;
        new_limit = limit_t2_q;
      end
      default: type_ok = 1'b0;
    endcase
  end

  // cell row
  edfs_pkg::entry_t cell_ent  [edfs_pkg::QUEUE_DEPTH];
  edfs_pkg::entry_t cell_tick [edfs_pkg::QUEUE_DEPTH];
  logic             cell_cond [edfs_pkg::QUEUE_DEPTH];
  edfs_pkg::entry_t new_ent;
  edfs_pkg::ctl_t   ctl;

  assign new_ent.valid    = 1'b1;
  assign new_ent.kind     = job_type_i;
  assign new_ent.work     = new_work;
  assign new_ent.deadline = signed'({{(edfs_pkg::DL_W-edfs_pkg::TIME_W){1'b0}}, new_limit});
  assign new_ent.started  = 1'b0;

  edfs_pkg::entry_t head;
  logic             full;
  logic             accept;
  logic             do_arrive, do_drop, do_tick, do_finish;

  assign head   = cell_ent[0];
  assign full   = cell_ent[edfs_pkg::QUEUE_DEPTH-1].valid;
  assign accept = start && !busy;

  assign do_arrive = accept && command_i == edfs_pkg::CMD_ARRIVE && type_ok && !full;
  assign do_drop   = accept && command_i == edfs_pkg::CMD_ARRIVE && type_ok && full;
  assign do_tick   = accept && command_i == edfs_pkg::CMD_TICK && head.valid;
  // head work of 0 or 1 runs out on this tick
  assign do_finish = do_tick && head.work < edfs_pkg::TIME_W'(2);

  // first-time head: only after an arrival or a finish, in the check state that follows
  logic chk_q;
  logic recv;
  assign recv = state_q == ST_CHECK && chk_q && head.valid && !head.started;

  assign ctl.arrive     = do_arrive;
  assign ctl.tick       = do_tick;
  assign ctl.finish     = do_finish;
  assign ctl.mark_start = recv;

  for (genvar i = 0; i < edfs_pkg::QUEUE_DEPTH; i++) begin : g_cell
    edfs_pkg::entry_t left_ent, right_tick;
    logic             left_cond;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_cond = 1'b0;
    end else begin : g_inner_l
      assign left_ent  = cell_ent[i-1];
      assign left_cond = cell_cond[i-1];
    end

    if (i == edfs_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_tick = '0;
    end else begin : g_inner_r
      assign right_tick = cell_tick[i+1];
    end

    edfs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .head_i      (i == 0),
      .new_i       (new_ent),
      .left_i      (left_ent),
      .left_cond_i (left_cond),
      .right_tick_i(right_tick),
      .entry_o     (cell_ent[i]),
      .tick_o      (cell_tick[i]),
      .cond_o      (cell_cond[i])
    );
  end

  // per-type serial counters and their selection
  logic [edfs_pkg::TIME_W-1:0] serial_q [3];
  logic [edfs_pkg::TIME_W-1:0] head_serial_inc;
  logic [edfs_pkg::TIME_W-1:0] fin_serial;

  logic                        drop_q, fin_q;
  logic [edfs_pkg::KIND_W-1:0] kind_q;
  logic [edfs_pkg::TIME_W-1:0] pend_serial_q;
  logic [edfs_pkg::KIND_W-1:0] pend_kind_q;

  always_comb begin
    head_serial_inc = '0;
    case (head.kind)
      edfs_pkg::KIND_T0: head_serial_inc = serial_q[0] + edfs_pkg::TIME_W'(1);
      edfs_pkg::KIND_T1: head_serial_inc = serial_q[1] + edfs_pkg::TIME_W'(1);
      edfs_pkg::KIND_T2: head_serial_inc = serial_q[2] + edfs_pkg::TIME_W'(1);
      default:           head_serial_inc = '0;
    endcase
  end

  always_comb begin
    fin_serial = '0;
    case (kind_q)
      edfs_pkg::KIND_T0: fin_serial = serial_q[0];
      edfs_pkg::KIND_T1: fin_serial = serial_q[1];
      edfs_pkg::KIND_T2: fin_serial = serial_q[2];
      default:           fin_serial = '0;
    endcase
  end

  assign busy = state_q != ST_IDLE;

  // sequencer and registered result port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      chk_q          <= 1'b0;
      drop_q         <= 1'b0;
      fin_q          <= 1'b0;
      kind_q         <= '0;
      pend_serial_q  <= '0;
      pend_kind_q    <= '0;
      serial_q[0]    <= '0;
      serial_q[1]    <= '0;
      serial_q[2]    <= '0;
      res_valid_o    <= 1'b0;
      event_res_o    <= edfs_pkg::EV_RECEIVE;
      job_type_res_o <= '0;
      serial_o       <= '0;
      last_o         <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_CHECK;
            chk_q   <= do_arrive || do_finish;
            drop_q  <= do_drop;
            fin_q   <= do_finish;
            kind_q  <= do_drop ? job_type_i : head.kind;
          end
        end
        ST_CHECK: begin
          state_q <= ST_IDLE;
          if (recv) begin
            case (head.kind)
              edfs_pkg::KIND_T0: serial_q[0] <= head_serial_inc;
              edfs_pkg::KIND_T1: serial_q[1] <= head_serial_inc;
              edfs_pkg::KIND_T2: serial_q[2] <= head_serial_inc;
              default: ;
            endcase
          end
          if (drop_q) begin
            res_valid_o    <= 1'b1;
            event_res_o    <= edfs_pkg::EV_DROP;
            job_type_res_o <= kind_q;
            serial_o       <= '0;
            last_o         <= 1'b1;
          end else if (fin_q) begin
            // finish carries the serial before any receive bump
            res_valid_o    <= 1'b1;
            event_res_o    <= edfs_pkg::EV_FINISH;
            job_type_res_o <= kind_q;
            serial_o       <= fin_serial;
            last_o         <= !recv;
            if (recv) begin
              state_q       <= ST_SECOND;
              pend_kind_q   <= head.kind;
              pend_serial_q <= head_serial_inc;
            end
          end else if (recv) begin
            res_valid_o    <= 1'b1;
            event_res_o    <= edfs_pkg::EV_RECEIVE;
            job_type_res_o <= head.kind;
            serial_o       <= head_serial_inc;
            last_o         <= 1'b1;
          end
        end
        ST_SECOND: begin
          state_q        <= ST_IDLE;
          res_valid_o    <= 1'b1;
          event_res_o    <= edfs_pkg::EV_RECEIVE;
          job_type_res_o <= pend_kind_q;
          serial_o       <= pend_serial_q;
          last_o         <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result without last is always followed by the receive result
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o && event_res_o == edfs_pkg::EV_RECEIVE)
    else $error("missing second result");

  // drops are always the final result; this check does not cover lone receives
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o == edfs_pkg::EV_DROP |-> last_o)
    else $error("drop result not marked last");

  // an accepted transaction always occupies the block for the check cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("not busy after accepted transaction");

  // queue stays packed: a valid tail slot implies a valid head
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ent[edfs_pkg::QUEUE_DEPTH-1].valid |-> cell_ent[0].valid)
    else $error("queue not packed");
`endif

endmodule
